FILE: rtl/fractal_gradient_noise_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fractal gradient noise core
// Short forms for clocked implication checks with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef FRACTAL_GRADIENT_NOISE_CORE_ASSERT_SVH
`define FRACTAL_GRADIENT_NOISE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FGN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fgn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FGN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fgn assertion failed");

`endif

FILE: rtl/fgn_pkg.sv
// ---------------------------------------------------------------------------
// fgn_pkg
// Types and constants shared by the fractal gradient noise core.
// ---------------------------------------------------------------------------
package fgn_pkg;

  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
  localparam int unsigned HASH_SHIFT   = 13;
  localparam int unsigned SEED_STEP    = 1000;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 2'd2;

  localparam int CNT_W  = 5;   // effective octave count, up to 15
  localparam int AMP_W  = 17;  // amplitude, Q.16, at most 1.0
  localparam int ASUM_W = 22;  // sum of up to 15 amplitudes
  localparam int TOT_W  = 40;  // weighted octave sum, Q.31
  localparam int Q_W    = 15;  // quotient bits below saturation

  typedef struct packed {
    logic                    valid;
    logic signed [31:0]      x;
    logic signed [31:0]      y;
    logic [AMP_W-1:0]        amp;
    logic [ASUM_W-1:0]       asum;
    logic signed [TOT_W-1:0] tot;
  } oct_bus_t;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              sat;
    logic [TOT_W-1:0]  rem;
    logic [Q_W-1:0]    q;
    logic [ASUM_W-1:0] asum;
  } div_bus_t;

endpackage

FILE: rtl/fgn_octave_cell.sv
// ---------------------------------------------------------------------------
// fgn_octave_cell
// One octave: lattice hash, x/y blend and weighted accumulate, 9 stages.
// ---------------------------------------------------------------------------
module fgn_octave_cell import fgn_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [31:0]      noise_seed,
  input  logic [15:0]      persistence,
  input  logic [CNT_W-1:0] cnt,
  input  oct_bus_t         bus_i,
  output oct_bus_t         bus_o
);

  localparam logic [31:0] SEED_OFS = 32'(IDX * SEED_STEP);

  oct_bus_t bus_r [1:8];
  oct_bus_t out_r;
  oct_bus_t out_nxt;

  logic [31:0] px1_r, py1_r;
  logic [15:0] fx1_r, fy1_r, tx1_r, ty1_r;
  logic [31:0] h2_r [4];
  logic [15:0] fx2_r;
  logic [16:0] u2_r, v2_r, anx2_r;
  logic signed [15:0] g3_r [4];
  logic [15:0] fx3_r;
  logic [16:0] u3_r, v3_r, anx3_r;
  logic signed [32:0] a4_r [2];
  logic signed [32:0] b4_r [2];
  logic [16:0] u4_r, v4_r, anx4_r;
  logic signed [35:0] e5_r [2];
  logic signed [32:0] a5_r [2];
  logic [16:0] v5_r, anx5_r;
  logic signed [33:0] nx6_r [2];
  logic [16:0] v6_r, anx6_r;
  logic signed [33:0] nx7_r;
  logic signed [35:0] f7_r;
  logic [16:0] anx7_r;
  logic signed [TOT_W-1:0] p8_r;
  logic [16:0] anx8_r;

  logic active;
  assign active = (CNT_W'(IDX) < cnt);

  // stage 1 inputs
  logic [63:0] xs, ys;
  logic [31:0] ix, iy, sqx, sqy;
  assign xs  = 64'(bus_i.x) << IDX;
  assign ys  = 64'(bus_i.y) << IDX;
  assign ix  = xs[47:16];
  assign iy  = ys[47:16];
  assign sqx = xs[15:0] * xs[15:0];
  assign sqy = ys[15:0] * ys[15:0];

  // stage 2: corner hashes and smoothstep
  logic [31:0] n2 [4];
  logic [17:0] wx, wy;
  logic [33:0] upx, upy;
  logic [32:0] anp;
  assign n2[0] = px1_r + py1_r + noise_seed + SEED_OFS;
  assign n2[1] = n2[0] + HASH_MUL_X;
  assign n2[2] = n2[0] + HASH_MUL_Y;
  assign n2[3] = n2[0] + HASH_MUL_X + HASH_MUL_Y;
  assign wx  = 18'd196608 - {1'b0, fx1_r, 1'b0};
  assign wy  = 18'd196608 - {1'b0, fy1_r, 1'b0};
  assign upx = tx1_r * wx;
  assign upy = ty1_r * wy;
  assign anp = bus_r[1].amp * persistence;

  // stage 3: mix multiply, gradient extraction
  logic [31:0] hm [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hm[k] = h2_r[k] * HASH_MUL_MIX;
    end
  end

  // stage 4: gradient products (corners 0/1 form row y, 2/3 row y+1)
  logic signed [16:0] fxs;
  logic signed [17:0] fxm;
  assign fxs = $signed({1'b0, fx3_r});
  assign fxm = 18'(fxs) - 18'sd65536;

  // stage 5: blend along x
  logic signed [33:0] dab [2];
  logic signed [51:0] pab [2];
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      dab[k] = 34'(b4_r[k]) - 34'(a4_r[k]);
      pab[k] = dab[k] * $signed({1'b0, u4_r});
    end
  end

  // stage 7: blend along y
  logic signed [34:0] dn;
  logic signed [52:0] pn;
  assign dn = 35'(nx6_r[1]) - 35'(nx6_r[0]);
  assign pn = dn * $signed({1'b0, v6_r});

  // stage 8: octave value times amplitude
  logic signed [35:0] s8;
  logic signed [19:0] oct8;
  assign s8   = 36'(nx7_r) + f7_r;
  assign oct8 = s8[35:16];

  // stage 9: accumulate when this octave is in use
  always_comb begin
    out_nxt      = bus_r[8];
    out_nxt.amp  = anx8_r;
    out_nxt.asum = bus_r[8].asum + (active ? ASUM_W'(bus_r[8].amp) : '0);
    out_nxt.tot  = bus_r[8].tot + (active ? p8_r : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 8; k++) begin
        bus_r[k].valid <= 1'b0;
      end
      out_r.valid <= 1'b0;
    end else if (en) begin
      bus_r[1] <= bus_i;
      for (int k = 2; k <= 8; k++) begin
        bus_r[k] <= bus_r[k-1];
      end
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r <= ix * HASH_MUL_X;
      py1_r <= iy * HASH_MUL_Y;
      fx1_r <= xs[15:0];
      fy1_r <= ys[15:0];
      tx1_r <= sqx[31:16];
      ty1_r <= sqy[31:16];

      for (int k = 0; k < 4; k++) begin
        h2_r[k] <= n2[k] ^ (n2[k] >> HASH_SHIFT);
      end
      fx2_r  <= fx1_r;
      u2_r   <= upx[32:16];
      v2_r   <= upy[32:16];
      anx2_r <= anp[32:16];

      for (int k = 0; k < 4; k++) begin
        g3_r[k] <= $signed({~hm[k][30], hm[k][29:15]});
      end
      fx3_r  <= fx2_r;
      u3_r   <= u2_r;
      v3_r   <= v2_r;
      anx3_r <= anx2_r;

      a4_r[0] <= g3_r[0] * fxs;
      b4_r[0] <= g3_r[1] * fxm;
      a4_r[1] <= g3_r[2] * fxs;
      b4_r[1] <= g3_r[3] * fxm;
      u4_r    <= u3_r;
      v4_r    <= v3_r;
      anx4_r  <= anx3_r;

      for (int k = 0; k < 2; k++) begin
        e5_r[k] <= 36'(pab[k] >>> 16);
        a5_r[k] <= a4_r[k];
      end
      v5_r   <= v4_r;
      anx5_r <= anx4_r;

      for (int k = 0; k < 2; k++) begin
        nx6_r[k] <= 34'(36'(a5_r[k]) + e5_r[k]);
      end
      v6_r   <= v5_r;
      anx6_r <= anx5_r;

      nx7_r  <= nx6_r[0];
      f7_r   <= 36'(pn >>> 16);
      anx7_r <= anx6_r;

      p8_r   <= oct8 * $signed({1'b0, bus_r[7].amp});
      anx8_r <= anx7_r;
    end
  end

  assign bus_o = out_r;

endmodule

FILE: rtl/fgn_div_cell.sv
// ---------------------------------------------------------------------------
// fgn_div_cell
// One restoring-division step: settles quotient bit BIT.
// ---------------------------------------------------------------------------
module fgn_div_cell import fgn_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  div_bus_t bus_i,
  output div_bus_t bus_o
);

  div_bus_t bus_r;
  div_bus_t bus_nxt;
  logic [TOT_W-1:0] dsr;
  logic             take;

  assign dsr  = TOT_W'(bus_i.asum) << BIT;
  assign take = (bus_i.rem >= dsr);

  always_comb begin
    bus_nxt        = bus_i;
    bus_nxt.rem    = take ? bus_i.rem - dsr : bus_i.rem;
    bus_nxt.q[BIT] = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else if (en) begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_o = bus_r;

endmodule

FILE: rtl/fractal_gradient_noise_core.sv
// ---------------------------------------------------------------------------
// fractal_gradient_noise_core
// Fractal lattice noise: a Q16.16 coordinate pair in, a Q1.15 value out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries in_x_coord and in_y_coord; a
//   transaction completes when in_valid is high and in_stall is low. The
//   result channel out_valid/out_stall carries out_noise_value the same way.
//   Config writes use cfg_valid/cfg_ready with cfg_index (0 seed, 1 octave
//   count, 2 persistence) and cfg_data; cfg_ready is always high, other
//   indexes are dropped. Write config only while no item is in flight.
// Throughput: one item per clock while no held result is stalled.
// Pipeline: a row of octave cells (9 stages each, one per octave), then a
//   front stage, one division cell per quotient bit and the output register.
// Stall: the whole row advances together; while a result sits in the output
//   register and out_stall is high, in_stall is high and every stage holds.
//   A result taken this cycle frees the row, so an item is accepted then.
// Reset: rst_n (synchronous, low) empties all stages and loads seed 0,
//   4 octaves and persistence 0.5.
// ---------------------------------------------------------------------------
`include "fractal_gradient_noise_core_assert.svh"

module fractal_gradient_noise_core import fgn_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_x_coord,
  input  logic signed [31:0]   in_y_coord,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_noise_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // config registers
  logic [31:0] noise_seed_r;
  logic [3:0]  octave_count_r;
  logic [15:0] persistence_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_seed_r   <= 32'd0;
      octave_count_r <= 4'd4;
      persistence_r  <= 16'd32768;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NOISE_SEED:   noise_seed_r   <= cfg_data;
        REG_OCTAVE_COUNT: octave_count_r <= cfg_data[3:0];
        REG_PERSISTENCE:  persistence_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // effective octave count: zero acts as one, clamp at MAX_OCTAVES
  logic [CNT_W-1:0] cnt;
  always_comb begin
    if (octave_count_r == 4'd0) begin
      cnt = CNT_W'(1);
    end else if (CNT_W'(octave_count_r) > CNT_W'(MAX_OCTAVES)) begin
      cnt = CNT_W'(MAX_OCTAVES);
    end else begin
      cnt = CNT_W'(octave_count_r);
    end
  end

  // global advance: hold everything only while the result waits
  logic out_valid_r;
  logic signed [15:0] out_noise_value_r;
  logic en;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // octave row; first amplitude is 1.0
  oct_bus_t chain [0:MAX_OCTAVES];
  always_comb begin
    chain[0].valid = in_valid;
    chain[0].x     = in_x_coord;
    chain[0].y     = in_y_coord;
    chain[0].amp   = AMP_W'(17'd65536);
    chain[0].asum  = '0;
    chain[0].tot   = '0;
  end

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fgn_octave_cell #(.IDX(i)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .noise_seed  (noise_seed_r),
      .persistence (persistence_r),
      .cnt         (cnt),
      .bus_i       (chain[i]),
      .bus_o       (chain[i+1])
    );
  end

  // division front: magnitude and saturation test against asum * 2^15
  oct_bus_t         last;
  logic [TOT_W-1:0] mag;
  div_bus_t         div_front_r;
  assign last = chain[MAX_OCTAVES];
  assign mag  = last.tot[TOT_W-1] ? TOT_W'(-last.tot) : TOT_W'(last.tot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_front_r.valid <= 1'b0;
    end else if (en) begin
      div_front_r.valid <= last.valid;
      div_front_r.neg   <= last.tot[TOT_W-1];
      div_front_r.sat   <= (mag >= (TOT_W'(last.asum) << Q_W));
      div_front_r.rem   <= mag;
      div_front_r.q     <= '0;
      div_front_r.asum  <= last.asum;
    end
  end

  div_bus_t dchain [0:Q_W];
  assign dchain[0] = div_front_r;

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    fgn_div_cell #(.BIT(Q_W-1-k)) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .bus_i (dchain[k]),
      .bus_o (dchain[k+1])
    );
  end

  // sign and saturate; quotient already truncated toward zero
  div_bus_t           dlast;
  logic signed [15:0] qs;
  logic signed [15:0] res;
  assign dlast = dchain[Q_W];
  assign qs    = $signed({1'b0, dlast.q});
  always_comb begin
    if (dlast.sat) begin
      res = dlast.neg ? 16'sh8000 : 16'sh7fff;
    end else begin
      res = dlast.neg ? -qs : qs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dlast.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_noise_value_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_value_r;

  `FGN_ASSERT_IMPL(a_stall_only_on_held_result, clk, rst_n, in_stall, out_valid_r && out_stall)
  `FGN_ASSERT_NEXT(a_div_to_out, clk, rst_n, dlast.valid && en, out_valid_r)
  `FGN_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt >= CNT_W'(1) && cnt <= CNT_W'(MAX_OCTAVES))

endmodule

FILE: bench/tb_fractal_gradient_noise_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fractal gradient noise core testbench
// Drives coordinate pairs through the core under several register settings,
// predicts each noise value in the bench and checks the results in order.
// ----------------------------------------------------------------------------
module tb_fractal_gradient_noise_core import fgn_pkg::*;;

  localparam int MAX_OCT    = 8;
  localparam int PIPE_LAT   = 9 * MAX_OCT + 17;  // octave cells, front stage, division cells and output register
  localparam int IDLE_LIMIT = 4000;              // cycles with no transaction at all
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [31:0]   in_x_coord = '0;
  logic signed [31:0]   in_y_coord = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [15:0]   out_noise_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // Bench copy of the registers, reset values of the core.
  logic [31:0] seed_reg = 32'd0;
  logic [3:0]  octaves_reg = 4'd4;
  logic [15:0] persist_reg = 16'd32768;

  logic signed [15:0] noise_expected[$];
  int mismatches = 0;
  int failures = 0;
  int coords_sent = 0;
  int values_checked = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;  // no gaps and no stalls while set

  fractal_gradient_noise_core #(.MAX_OCTAVES(MAX_OCT)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_noise_value(out_noise_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Noise predictor
  // --------------------------------------------------------------------------

  // Corner hash folded into a signed Q1.15 scalar gradient.
  function automatic longint corner_gradient(logic [31:0] ix, logic [31:0] iy,
                                             logic [31:0] sd);
    logic [31:0] n;
    longint g;
    n = ix * HASH_MUL_X + iy * HASH_MUL_Y + sd;
    n = (n ^ (n >> HASH_SHIFT)) * HASH_MUL_MIX;
    g = n[30:15];
    return g - 32768;
  endfunction

  function automatic longint smoothstep_q16(longint t);
    longint t2;
    t2 = (t * t) >>> 16;
    return (t2 * (3 * 65536 - 2 * t)) >>> 16;
  endfunction

  function automatic longint lerp_row(longint g0, longint g1, longint fx, longint u);
    longint a, b;
    a = g0 * fx;
    b = g1 * (fx - 65536);
    return a + ((u * (b - a)) >>> 16);
  endfunction

  function automatic longint octave_noise(longint x, longint y, int sh, logic [31:0] sd);
    logic [63:0] xs, ys;
    logic [31:0] ix, iy;
    longint fx, fy, u, v, r0, r1, s;
    xs = 64'(x) << sh;
    ys = 64'(y) << sh;
    fx = xs[15:0];
    fy = ys[15:0];
    ix = xs[47:16];
    iy = ys[47:16];
    u  = smoothstep_q16(fx);
    v  = smoothstep_q16(fy);
    r0 = lerp_row(corner_gradient(ix, iy, sd), corner_gradient(ix + 1, iy, sd), fx, u);
    r1 = lerp_row(corner_gradient(ix, iy + 1, sd), corner_gradient(ix + 1, iy + 1, sd),
                  fx, u);
    s  = r0 + ((v * (r1 - r0)) >>> 16);
    return s >>> 16;
  endfunction

  function automatic logic signed [15:0] predict_noise(logic signed [31:0] x,
                                                       logic signed [31:0] y);
    int count;
    longint total, ampsum, amp, r;
    logic [31:0] sd;
    count = octaves_reg;
    if (count < 1) count = 1;
    if (count > MAX_OCT) count = MAX_OCT;
    total = 0;
    ampsum = 0;
    amp = 65536;
    for (int i = 0; i < count; i++) begin
      sd = seed_reg + 32'(i) * 32'(SEED_STEP);
      total += octave_noise(longint'(x), longint'(y), i, sd) * amp;
      ampsum += amp;
      amp = (amp * longint'(persist_reg)) >>> 16;
    end
    r = total / ampsum;  // truncates toward zero
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One coordinate transaction; valid stays high across back-to-back sends.
  task automatic send_coord(logic signed [31:0] x, logic signed [31:0] y);
    int gap;
    in_valid   <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    do @(posedge clk); while (in_stall);
    noise_expected.push_back(predict_noise(x, y));
    coords_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets the pipe empty, then lets the latency pass before touching a register.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_NOISE_SEED:   seed_reg = data;
      REG_OCTAVE_COUNT: octaves_reg = data[3:0];
      REG_PERSISTENCE:  persist_reg = data[15:0];
      default: ;  // unmapped index, core drops it
    endcase
  endtask

  task automatic send_random(int n);
    logic signed [31:0] x, y;
    for (int k = 0; k < n; k++) begin
      // mix of full-range and near-origin coordinates
      if ($urandom_range(0, 3) == 0) begin
        x = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        y = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      end else begin
        x = $urandom;
        y = $urandom;
      end
      send_coord(x, y);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall pattern, checker, watchdog
  // --------------------------------------------------------------------------

  initial begin : stall_gen
    int r, n;
    @(posedge rst_n);
    forever begin
      r = $urandom_range(0, 99);
      if (quiet || r >= 50) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b0;
      end else if (r < 10) begin
        n = $urandom_range(10, 40);
        out_stall <= 1'b1;
      end else begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (noise_expected.size() == 0) begin
        failures++;
        if (mismatches < 10)
          $display("[%0t] unexpected noise value %0d", $realtime, out_noise_value);
        mismatches++;
      end else begin
        logic signed [15:0] want;
        want = noise_expected.pop_front();
        values_checked++;
        if (out_noise_value !== want) begin
          failures++;
          if (mismatches < 10)
            $display("[%0t] noise_value mismatch: expected %0d, got %0d",
                     $realtime, want, out_noise_value);
          mismatches++;
        end
      end
    end
  end

  // Counts cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired, %0d values still expected", noise_expected.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: corners of the coordinate range and lattice boundaries.
  task automatic test_extremes();
    send_coord(32'sh0000_0000, 32'sh0000_0000);
    send_coord(32'sh8000_0000, 32'sh8000_0000);
    send_coord(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_coord(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_coord(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_coord(32'sh0000_FFFF, 32'sh0000_FFFF);
    send_coord(32'sh0001_0000, 32'sh0001_0000);
    send_coord(-32'sd1, -32'sd1);
    send_coord(32'sd1, -32'sd65536);
    send_coord(32'sh0000_8000, 32'sh0000_8000);
    send_coord(32'shFFFF_0000, 32'sh7FFF_0000);
    send_coord(32'shAAAA_AAAA, 32'sh5555_5555);
  endtask

  // Clamping of the octave count and the persistence extremes.
  task automatic test_octave_limits();
    write_reg(REG_OCTAVE_COUNT, 32'd0);   // treated as one octave
    send_coord(32'sh1234_5678, -32'sh0765_4321);
    send_coord(32'sh7FFF_FFFF, 32'sh8000_0000);
    write_reg(REG_OCTAVE_COUNT, 32'd15);  // clamps to the maximum
    send_coord(32'sh1234_5678, -32'sh0765_4321);
    send_coord(32'sh8000_0000, 32'sh7FFF_FFFF);
    write_reg(REG_OCTAVE_COUNT, 32'd9);
    send_coord(32'sh0003_C000, 32'sh0001_4000);
    write_reg(REG_PERSISTENCE, 32'd0);    // only the first octave weighs
    send_coord(32'sh1234_5678, -32'sh0765_4321);
    write_reg(REG_PERSISTENCE, 32'hFFFF_FFFF);
    write_reg(REG_NOISE_SEED, 32'hFFFF_FFFF);
    write_reg(REG_OCTAVE_COUNT, 32'd8);
    send_coord(32'sh1234_5678, -32'sh0765_4321);
    send_coord(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF); // must leave every register alone
    send_coord(32'sh0000_FFFF, -32'sd1);
  endtask

  // Random coordinates under a series of random register settings.
  task automatic test_random_coords();
    for (int phase = 0; phase < 9; phase++) begin
      write_reg(REG_NOISE_SEED, $urandom);
      write_reg(REG_OCTAVE_COUNT, (phase == 8) ? 32'd1 : $urandom_range(0, 15));
      write_reg(REG_PERSISTENCE, (phase == 0) ? 32'd0 : $urandom);
      quiet = (phase == 3);
      send_random(25);
      // hold off the sender until every pending value is back
      in_valid <= 1'b0;
      while (noise_expected.size() != 0) @(posedge clk);
      @(posedge clk);
      send_random(25);
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_octave_limits();
    test_random_coords();
    in_valid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    failures += noise_expected.size();
    $display("Sent %0d coordinate pairs, checked %0d noise values over %0d register writes,",
             coords_sent, values_checked, cfg_writes);
    $display("covering octave clamping, persistence extremes and random stalls.");
    if (failures == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: fractal_gradient_noise_core.f
+incdir+rtl
rtl/fgn_pkg.sv
rtl/fgn_octave_cell.sv
rtl/fgn_div_cell.sv
rtl/fractal_gradient_noise_core.sv
bench/tb_fractal_gradient_noise_core.sv
